>>> hdl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg: shared types, character codes and the byte rewrite function
// Used by the front end, the group queue and the back end of the rewriter.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int MAX_BYTES = 8;  // held byte (up to 5) plus final byte (up to 3)
  localparam int RW_BYTES  = 5;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Rewrite of one byte.
  typedef struct packed {
    logic [RW_BYTES-1:0][7:0] b;
    logic [2:0]               cnt;
    logic                     took;
  } rw_t;

  // All bytes caused by one input beat.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] b;
    logic [3:0]                cnt;
  } group_t;

  function automatic rw_t pad3(input logic [7:0] mid);
    rw_t r;
    r      = '0;
    r.b[0] = CH_SPACE;
    r.b[1] = mid;
    r.b[2] = CH_SPACE;
    r.cnt  = 3'd3;
    return r;
  endfunction

  function automatic rw_t pad4(input logic [7:0] c0, input logic [7:0] c1);
    rw_t r;
    r      = '0;
    r.b[0] = CH_SPACE;
    r.b[1] = c0;
    r.b[2] = c1;
    r.b[3] = CH_SPACE;
    r.cnt  = 3'd4;
    r.took = 1'b1;
    return r;
  endfunction

  function automatic rw_t rewrite(input logic [7:0] a, input logic has_nx,
                                  input logic [7:0] nx);
    rw_t r;
    r      = '0;
    r.b[0] = a;
    r.cnt  = 3'd1;
    if (a == CH_COMMA) begin
      r.b[0] = CH_SPACE;
    end else if (has_nx && a == CH_LT && nx == CH_MINUS) begin
      // "<-" keeps the '-' for the next step
      r.b[0] = CH_SPACE;
      r.b[1] = CH_LT;
      r.b[2] = CH_MINUS;
      r.b[3] = CH_GT;
      r.b[4] = CH_SPACE;
      r.cnt  = 3'd5;
    end else if (has_nx && a == CH_MINUS && nx == CH_GT) begin
      r.cnt  = 3'd0;
      r.took = 1'b1;
    end else if (has_nx && ((a == CH_EQ && nx == CH_GT) || (a == CH_LT && nx == CH_EQ) ||
                            (a == CH_GT && nx == CH_EQ) || (a == CH_BANG && nx == CH_EQ))) begin
      r = pad4(a, nx);
    end else if (has_nx && a == CH_HASH && nx == CH_LBRACK) begin
      r = pad4(CH_HASH, CH_LPAREN);
    end else begin
      case (a) inside
        CH_LPAREN, CH_LBRACK: r = pad3(CH_LPAREN);
        CH_RPAREN, CH_RBRACK: r = pad3(CH_RPAREN);
        CH_EQ, CH_GT, CH_LT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: r = pad3(a);
        CH_DOT:               r = pad3(CH_AMP);
        CH_NL:                r = pad3(CH_DOLLAR);
        default:              r = r;
      endcase
    end
    return r;
  endfunction

endpackage

>>> hdl/token_spacing_rewriter.sv
// ----------------------------------------------------------------------------
// token_spacing_rewriter: spaced-token rewrite of a source text byte stream
//
// Input channel (in_valid / in_stall): one text byte per beat, with
// end_of_text high on the final byte of a text. Output channel
// (out_valid / out_stall): rewritten bytes, last_of_run high on the final
// byte caused by one input beat. Beats that cause no bytes (a byte held
// back as lookahead, or a dropped "->") produce nothing on the output.
//
// With the output side idle, the first output byte of a beat is presented
// after the queue write and then the serializer load.
// Throughput: the front end takes one byte per cycle while the group queue
// has room; the serializer sends one byte per cycle while the receiver does
// not stall, and an input beat expands to 0 to 8 output bytes. The output
// port sets the sustained rate.
//
// Reset clears the held lookahead byte, the queue and the serializer.
// When the receiver stalls, the current byte holds; the queue keeps taking
// input beats until it is full (QUEUE_DEPTH groups), then in_stall rises.
// ----------------------------------------------------------------------------
module token_spacing_rewriter
  import tsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  group_t grp_in;
  group_t grp_out;

  // Queue full is the only input back-pressure.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tsr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .push        (push),
    .grp         (grp_in)
  );

  tsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (grp_in),
    .pop   (pop),
    .dout  (grp_out),
    .full  (q_full),
    .empty (q_empty)
  );

  tsr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (grp_out),
    .q_empty     (q_empty),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

>>> hdl/tsr_front.sv
// ----------------------------------------------------------------------------
// tsr_front: input side of the rewriter
// Holds one byte back, rewrites it against the incoming byte and builds the
// byte group for each accepted beat.
// ----------------------------------------------------------------------------
module tsr_front
  import tsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       push,
  output group_t     grp
);

  logic [7:0] held_char;
  logic       held_valid;
  logic [7:0] held_char_next;
  logic       held_valid_next;
  rw_t        r1;
  rw_t        r2;
  logic       pending;
  logic [3:0] j;

  always_comb begin
    r1 = '0;
    if (held_valid) begin
      r1 = rewrite(held_char, 1'b1, in_byte);
    end
    pending = !(held_valid && r1.took);
    r2 = '0;
    if (pending && end_of_text) begin
      r2 = rewrite(in_byte, 1'b0, 8'h00);
    end
    if (pending && !end_of_text) begin
      held_char_next  = in_byte;
      held_valid_next = 1'b1;
    end else begin
      held_char_next  = 8'h00;
      held_valid_next = 1'b0;
    end
  end

  // Pack the two rewrites back to back.
  always_comb begin
    grp     = '0;
    grp.cnt = {1'b0, r1.cnt} + {1'b0, r2.cnt};
    j       = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      j = 4'(i) - {1'b0, r1.cnt};
      if (4'(i) < {1'b0, r1.cnt}) begin
        if (i < RW_BYTES) begin
          grp.b[i] = r1.b[3'(i)];
        end
      end else if (j < 4'(RW_BYTES)) begin
        grp.b[i] = r2.b[j[2:0]];
      end
    end
  end

  assign push = accept && (grp.cnt != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char  <= 8'h00;
      held_valid <= 1'b0;
    end else if (accept) begin
      held_char  <= held_char_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

>>> hdl/tsr_queue.sv
// ----------------------------------------------------------------------------
// tsr_queue: short queue of byte groups
// Decouples the front end from the output serializer.
// ----------------------------------------------------------------------------
module tsr_queue
  import tsr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t din,
  input  logic   pop,
  output group_t dout,
  output logic   full,
  output logic   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  group_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

>>> hdl/tsr_back.sv
// ----------------------------------------------------------------------------
// tsr_back: output serializer
// Takes one byte group from the queue and sends it one byte per beat,
// marking the final byte of the group.
// ----------------------------------------------------------------------------
module tsr_back
  import tsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  group_t     q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  group_t     cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       advance;

  assign last_of_run = ({1'b0, idx} == cur.cnt - 4'd1);
  assign out_byte    = cur.b[idx];
  assign out_valid   = cur_valid;
  assign advance     = !cur_valid || (!out_stall && last_of_run);
  assign q_pop       = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (!out_stall) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

>>> tb/tb_token_spacing_rewriter.sv
// ----------------------------------------------------------------------------
// tb_token_spacing_rewriter: self-checking bench for the spaced-token rewriter
//
// Source texts go in one byte per beat. A local predictor keeps its own
// lookahead byte and works out the rewritten bytes of every accepted beat.
// Each output beat is checked against the oldest expected byte. Directed
// texts come first, then random texts under three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_token_spacing_rewriter;

  // character codes used by the predictor and the text generator
  localparam logic [7:0] C_SPACE    = " ";
  localparam logic [7:0] C_COMMA    = ",";
  localparam logic [7:0] C_AMP      = "&";
  localparam logic [7:0] C_DOLLAR   = "$";
  localparam logic [7:0] C_HASH     = "#";
  localparam logic [7:0] C_LBRACK   = "[";
  localparam logic [7:0] C_RBRACK   = "]";
  localparam logic [7:0] C_LPAREN   = "(";
  localparam logic [7:0] C_RPAREN   = ")";
  localparam logic [7:0] C_NL       = 8'h0A;
  localparam logic [7:0] C_LT       = "<";
  localparam logic [7:0] C_GT       = ">";
  localparam logic [7:0] C_EQ       = "=";
  localparam logic [7:0] C_BANG     = "!";
  localparam logic [7:0] C_MINUS    = "-";
  localparam logic [7:0] C_PLUS     = "+";
  localparam logic [7:0] C_STAR     = "*";
  localparam logic [7:0] C_SLASH    = "/";
  localparam logic [7:0] C_PCT      = "%";
  localparam logic [7:0] C_DOT      = ".";
  localparam logic [7:0] C_NUL      = 8'h00;
  localparam logic [7:0] C_ALL_ONES = 8'hFF;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED  = 40;
  localparam int RANDOM_ITEMS = 130;   // per idle mix, three mixes

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  // idle rates in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int errors = 0;

  // predictor state: the byte waiting for its lookahead
  logic [7:0] held_byte = 8'h00;
  logic       have_held = 1'b0;

  logic [7:0] token_bytes[$];     // bytes of one beat, built by the predictor
  out_beat_t  expected_beats[$];  // rewritten bytes still to come out
  out_beat_t  oldest_beat;
  logic [7:0] text_q[$];          // text being sent

  string      duo_ops[7] = '{"=>", "<=", ">=", "!=", "#[", "->", "<-"};
  string      solo_ops   = "=<>!#[]()-+*/%.,\n";

  token_spacing_rewriter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void pad_one(input logic [7:0] mid);
    token_bytes.push_back(C_SPACE);
    token_bytes.push_back(mid);
    token_bytes.push_back(C_SPACE);
  endfunction

  // Spell byte cur, with nxt as lookahead when has_next. Sets took when the
  // lookahead is swallowed by a two-byte token.
  function automatic void spell_token(input logic [7:0] cur, input logic has_next,
                                      input logic [7:0] nxt, output logic took);
    took = 1'b0;
    if (cur == C_COMMA) begin
      token_bytes.push_back(C_SPACE);
    end else if (has_next && cur == C_LT && nxt == C_MINUS) begin
      // left arrow: emit " <-> " but leave the '-' as the next held byte
      token_bytes.push_back(C_SPACE);
      token_bytes.push_back(C_LT);
      token_bytes.push_back(C_MINUS);
      token_bytes.push_back(C_GT);
      token_bytes.push_back(C_SPACE);
    end else if (has_next && cur == C_MINUS && nxt == C_GT) begin
      took = 1'b1;  // right arrow vanishes
    end else if (has_next && ((cur == C_EQ && nxt == C_GT) || (cur == C_LT && nxt == C_EQ) ||
                              (cur == C_GT && nxt == C_EQ) || (cur == C_BANG && nxt == C_EQ))) begin
      took = 1'b1;
      token_bytes.push_back(C_SPACE);
      token_bytes.push_back(cur);
      token_bytes.push_back(nxt);
      token_bytes.push_back(C_SPACE);
    end else if (has_next && cur == C_HASH && nxt == C_LBRACK) begin
      took = 1'b1;
      token_bytes.push_back(C_SPACE);
      token_bytes.push_back(C_HASH);
      token_bytes.push_back(C_LPAREN);
      token_bytes.push_back(C_SPACE);
    end else begin
      case (cur)
        C_LPAREN, C_LBRACK: pad_one(C_LPAREN);
        C_RPAREN, C_RBRACK: pad_one(C_RPAREN);
        C_EQ, C_GT, C_LT, C_PLUS, C_MINUS, C_STAR, C_SLASH, C_PCT: pad_one(cur);
        C_DOT:              pad_one(C_AMP);
        C_NL:               pad_one(C_DOLLAR);
        default:            token_bytes.push_back(cur);
      endcase
    end
  endfunction

  // One accepted input beat: release the held byte, then hold or flush cur.
  function automatic void predict_rewrite(input logic [7:0] cur, input logic eot);
    logic      took;
    out_beat_t entry;
    token_bytes.delete();
    took = 1'b0;
    if (have_held) spell_token(held_byte, 1'b1, cur, took);
    if (!took && !eot) begin
      held_byte = cur;
      have_held = 1'b1;
    end else begin
      // text end or swallowed lookahead: a byte that was not swallowed is spelled with no lookahead
      if (!took) spell_token(cur, 1'b0, C_NUL, took);
      held_byte = 8'h00;
      have_held = 1'b0;
    end
    foreach (token_bytes[i]) begin
      entry.ch   = token_bytes[i];
      entry.last = (i == token_bytes.size() - 1);
      expected_beats.push_back(entry);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected out_byte %02h last_of_run %0b",
                                  out_byte, last_of_run));
      end else begin
        oldest_beat = expected_beats.pop_front();
        if (out_byte !== oldest_beat.ch)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, oldest_beat.ch));
        if (last_of_run !== oldest_beat.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b (out_byte %02h)",
                                    last_of_run, oldest_beat.last, out_byte));
      end
    end
  end

  // receiver back-pressure, drawn fresh every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ends the run when neither side moves a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Send one beat. Called at a rising edge; returns at the edge that took it,
  // leaving valid high so a back-to-back beat needs no extra cycle.
  task automatic send_beat(input logic [7:0] cur, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= cur;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    predict_rewrite(cur, eot);
  endtask

  task automatic send_queued_text();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(input string txt);
    text_q.delete();
    for (int i = 0; i < txt.len(); i++) text_q.push_back(txt[i]);
    send_queued_text();
  endtask

  // every two-byte token but the left arrow back to back, plus the right arrow being dropped
  task automatic test_two_byte_tokens();
    send_text("a=><=>=!=#[->b");
  endtask

  // left arrow whose '-' is the final byte: the arrow and the padded '-'
  // come out of one beat, the longest burst of one beat
  task automatic test_left_arrow_at_end();
    send_text("<-");
  endtask

  // brackets, comma, dot and newline; text ends on a swallowed lookahead
  task automatic test_single_tokens();
    send_text(",[.\n]!=");
  endtask

  // one-byte texts: nothing held yet, odd bytes pass through
  task automatic test_odd_bytes();
    send_beat(C_ALL_ONES, 1'b1);
    send_beat(C_NUL, 1'b1);
  endtask

  // Random texts of 1 to 12 bytes, mostly token-rich with some raw bytes.
  task automatic test_random_texts(input int n_items);
    int sent;
    int len;
    int pick;
    string duo;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      text_q.delete();
      while (text_q.size() < len) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          duo = duo_ops[$urandom_range(6)];
          text_q.push_back(duo[0]);
          text_q.push_back(duo[1]);
        end else if (pick < 65) begin
          text_q.push_back(solo_ops[$urandom_range(solo_ops.len() - 1)]);
        end else if (pick < 85) begin
          text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end else begin
          text_q.push_back(8'($urandom_range(255)));
        end
      end
      while (text_q.size() > len) void'(text_q.pop_back());
      send_queued_text();
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sparse sender gaps, heavy receiver stall
    send_idle_pct = 6;
    recv_idle_pct = 70;
    test_two_byte_tokens();
    test_left_arrow_at_end();
    test_single_tokens();
    test_odd_bytes();
    test_random_texts(RANDOM_ITEMS);

    // heavy sender gaps, light stall
    send_idle_pct = 70;
    recv_idle_pct = 6;
    test_random_texts(RANDOM_ITEMS);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
